// File: rtl/e2rm_pkg.sv
package e2rm_pkg;

	// Inverse gain of an endless CORDIC rotator, Q32. The same value is used for every stage count.
	localparam logic signed [34:0] GAIN_Q32 = 35'sd2608131497;

	// Largest number of rotation stages that the angle table supports.
	localparam int MAX_STAGES = 32;

	// Rotation angle of stage idx, atan(2^-idx), in binary angle units (2^32 per turn).
	function automatic logic [31:0] atan_q32(input int idx);
		logic [31:0] r;
		unique case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/e2rm_in_if.sv
interface e2rm_in_if #(
	parameter int ANGLE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] bank_angle;
	logic signed [ANGLE_BITS-1:0] attitude_angle;
	logic signed [ANGLE_BITS-1:0] heading_angle;

	modport source (output valid, bank_angle, attitude_angle, heading_angle, input ready);
	modport sink (input valid, bank_angle, attitude_angle, heading_angle, output ready);
endinterface

// File: rtl/e2rm_out_if.sv
interface e2rm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r00;
	logic signed [15:0] r01;
	logic signed [15:0] r02;
	logic signed [15:0] r10;
	logic signed [15:0] r11;
	logic signed [15:0] r12;
	logic signed [15:0] r20;
	logic signed [15:0] r21;
	logic signed [15:0] r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

// File: rtl/euler_to_rotation_matrix_top.sv
// Pipeline: an accepted input beat passes through one angle fold stage, one stage per CORDIC
// rotation (at most 32) and six product, sum and rounding stages before its result beat.
// Throughput: one beat per cycle; the whole pipeline advances together when out_ch is free.
// Reset: arst_n clears the valid bits of all stages asynchronously; data registers are not reset.
module euler_to_rotation_matrix_top #(
	parameter int ANGLE_BITS    = 16,
	parameter int FRAC_BITS     = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	e2rm_in_if.sink     in_ch,
	e2rm_out_if.source  out_ch
);

	localparam int NST = (CORDIC_STAGES > e2rm_pkg::MAX_STAGES) ?
		e2rm_pkg::MAX_STAGES : CORDIC_STAGES;
	localparam int RSH = 60 - FRAC_BITS;

	// Product slots of the first multiplier stage.
	localparam int P_CHCA = 0;
	localparam int P_SHSB = 1;
	localparam int P_CHSA = 2;
	localparam int P_SHCB = 3;
	localparam int P_CACB = 4;
	localparam int P_CASB = 5;
	localparam int P_SHCA = 6;
	localparam int P_CHSB = 7;
	localparam int P_SHSA = 8;
	localparam int P_CHCB = 9;
	localparam int NPROD  = 10;

	// Angle slots: bank, attitude, heading.
	localparam int A_B = 0;
	localparam int A_A = 1;
	localparam int A_H = 2;

	logic adv;

	// CORDIC pipeline, one register slice per rotation.
	logic signed [34:0] cx_s [3][NST+1];
	logic signed [34:0] cy_s [3][NST+1];
	logic signed [33:0] cz_s [3][NST+1];
	logic               cf_s [3][NST+1];
	logic               cv_s [NST+1];

	logic [ANGLE_BITS-1:0] ang_w [3];
	logic [31:0]           u_w [3];
	logic [31:0]           ur_w [3];
	logic                  flip_w [3];

	logic signed [31:0] cos_s1 [3];
	logic signed [31:0] sin_s1 [3];
	logic               v_s1;

	logic signed [63:0] prod_s2 [NPROD];
	logic signed [31:0] cb_s2, sb_s2, sa_s2;
	logic               v_s2;

	logic signed [63:0] prod_s3 [NPROD];
	logic signed [31:0] chsa_s3, shsa_s3, cb_s3, sb_s3, sa_s3;
	logic               v_s3;

	logic signed [63:0] prod_s4 [NPROD];
	logic signed [63:0] chsacb_s4, chsasb_s4, shsacb_s4, shsasb_s4;
	logic signed [31:0] sa_s4;
	logic               v_s4;

	logic signed [63:0] ent_s5 [9];
	logic               v_s5;

	logic signed [15:0] fin_s6 [9];
	logic               v_s6;

	logic signed [63:0] rnd_w [9];
	logic signed [63:0] chsa_w, shsa_w;

	// The whole pipeline moves when the output register is empty or being drained.
	assign adv         = !v_s6 || out_ch.ready;
	assign in_ch.ready = adv;

	// Left-align each angle to 32 bits and fold the second and third quadrants by a half turn.
	assign ang_w[A_B] = in_ch.bank_angle;
	assign ang_w[A_A] = in_ch.attitude_angle;
	assign ang_w[A_H] = in_ch.heading_angle;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			u_w[a]    = 32'(ang_w[a]) << (32 - ANGLE_BITS);
			flip_w[a] = (u_w[a][31:30] == 2'b01) || (u_w[a][31:30] == 2'b10);
			ur_w[a]   = flip_w[a] ? (u_w[a] + 32'h80000000) : u_w[a];
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) cv_s[k] <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			cv_s[0] <= in_ch.valid;
			for (int k = 1; k <= NST; k++) cv_s[k] <= cv_s[k-1];
			v_s1 <= cv_s[NST];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Entry slice of the rotator.
	for (genvar a = 0; a < 3; a++) begin : g_entry
		always_ff @(posedge clk) begin
			if (adv) begin
				cx_s[a][0] <= e2rm_pkg::GAIN_Q32;
				cy_s[a][0] <= '0;
				cz_s[a][0] <= 34'(signed'(ur_w[a]));
				cf_s[a][0] <= flip_w[a];
			end
		end
	end

	// One rotation per slice, shift and angle fixed by the slice position.
	for (genvar k = 0; k < NST; k++) begin : g_rot
		for (genvar a = 0; a < 3; a++) begin : g_ang
			localparam logic signed [33:0] ATN = 34'(signed'({2'b00, e2rm_pkg::atan_q32(k)}));
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!cz_s[a][k][33]) begin
						cx_s[a][k+1] <= cx_s[a][k] - (cy_s[a][k] >>> k);
						cy_s[a][k+1] <= cy_s[a][k] + (cx_s[a][k] >>> k);
						cz_s[a][k+1] <= cz_s[a][k] - ATN;
					end else begin
						cx_s[a][k+1] <= cx_s[a][k] + (cy_s[a][k] >>> k);
						cy_s[a][k+1] <= cy_s[a][k] - (cx_s[a][k] >>> k);
						cz_s[a][k+1] <= cz_s[a][k] + ATN;
					end
					cf_s[a][k+1] <= cf_s[a][k];
				end
			end
		end
	end

	// Round cosine and sine to Q30 and undo the half-turn fold.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				cos_s1[a] <= cf_s[a][NST] ?
					-32'((cx_s[a][NST] + 35'sd2) >>> 2) : 32'((cx_s[a][NST] + 35'sd2) >>> 2);
				sin_s1[a] <= cf_s[a][NST] ?
					-32'((cy_s[a][NST] + 35'sd2) >>> 2) : 32'((cy_s[a][NST] + 35'sd2) >>> 2);
			end
		end
	end

	// Pairwise products in Q60.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2[P_CHCA] <= 64'(cos_s1[A_H]) * 64'(cos_s1[A_A]);
			prod_s2[P_SHSB] <= 64'(sin_s1[A_H]) * 64'(sin_s1[A_B]);
			prod_s2[P_CHSA] <= 64'(cos_s1[A_H]) * 64'(sin_s1[A_A]);
			prod_s2[P_SHCB] <= 64'(sin_s1[A_H]) * 64'(cos_s1[A_B]);
			prod_s2[P_CACB] <= 64'(cos_s1[A_A]) * 64'(cos_s1[A_B]);
			prod_s2[P_CASB] <= 64'(cos_s1[A_A]) * 64'(sin_s1[A_B]);
			prod_s2[P_SHCA] <= 64'(sin_s1[A_H]) * 64'(cos_s1[A_A]);
			prod_s2[P_CHSB] <= 64'(cos_s1[A_H]) * 64'(sin_s1[A_B]);
			prod_s2[P_SHSA] <= 64'(sin_s1[A_H]) * 64'(sin_s1[A_A]);
			prod_s2[P_CHCB] <= 64'(cos_s1[A_H]) * 64'(cos_s1[A_B]);
			cb_s2 <= cos_s1[A_B];
			sb_s2 <= sin_s1[A_B];
			sa_s2 <= sin_s1[A_A];
		end
	end

	// Round the two shared pair products back to Q30 for the triple products.
	assign chsa_w = (prod_s2[P_CHSA] + (64'sd1 <<< 29)) >>> 30;
	assign shsa_w = (prod_s2[P_SHSA] + (64'sd1 <<< 29)) >>> 30;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_s2;
			chsa_s3 <= 32'(chsa_w);
			shsa_s3 <= 32'(shsa_w);
			cb_s3   <= cb_s2;
			sb_s3   <= sb_s2;
			sa_s3   <= sa_s2;
		end
	end

	// Triple products.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4   <= prod_s3;
			chsacb_s4 <= 64'(chsa_s3) * 64'(cb_s3);
			chsasb_s4 <= 64'(chsa_s3) * 64'(sb_s3);
			shsacb_s4 <= 64'(shsa_s3) * 64'(cb_s3);
			shsasb_s4 <= 64'(shsa_s3) * 64'(sb_s3);
			sa_s4     <= sa_s3;
		end
	end

	// Matrix entries in Q60.
	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s5[0] <= prod_s4[P_CHCA];
			ent_s5[1] <= prod_s4[P_SHSB] - chsacb_s4;
			ent_s5[2] <= chsasb_s4 + prod_s4[P_SHCB];
			ent_s5[3] <= 64'(sa_s4) <<< 30;
			ent_s5[4] <= prod_s4[P_CACB];
			ent_s5[5] <= -prod_s4[P_CASB];
			ent_s5[6] <= -prod_s4[P_SHCA];
			ent_s5[7] <= shsacb_s4 + prod_s4[P_CHSB];
			ent_s5[8] <= prod_s4[P_CHCB] - shsasb_s4;
		end
	end

	// Round to the output format and saturate to plus or minus one.
	always_comb begin
		for (int e = 0; e < 9; e++) begin
			rnd_w[e] = (ent_s5[e] + (64'sd1 <<< (RSH - 1))) >>> RSH;
			if (rnd_w[e] > (64'sd1 <<< FRAC_BITS)) begin
				rnd_w[e] = 64'sd1 <<< FRAC_BITS;
			end else if (rnd_w[e] < -(64'sd1 <<< FRAC_BITS)) begin
				rnd_w[e] = -(64'sd1 <<< FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 9; e++) fin_s6[e] <= rnd_w[e][15:0];
		end
	end

	assign out_ch.valid = v_s6;
	assign out_ch.r00   = fin_s6[0];
	assign out_ch.r01   = fin_s6[1];
	assign out_ch.r02   = fin_s6[2];
	assign out_ch.r10   = fin_s6[3];
	assign out_ch.r11   = fin_s6[4];
	assign out_ch.r12   = fin_s6[5];
	assign out_ch.r20   = fin_s6[6];
	assign out_ch.r21   = fin_s6[7];
	assign out_ch.r22   = fin_s6[8];

`ifndef SYNTH
	// A stalled pipeline holds the heading angle residue and the valid bit of the last rotation slice.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cz_s[A_H][NST]) && $stable(cv_s[NST]))
		else $error("rotator slice changed during a stall");

	// The diagonal entries of a valid result lie within plus or minus 16384 when FRAC_BITS is at most 14.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (FRAC_BITS > 14) ||
			((out_ch.r00 <= 16'sd16384) && (out_ch.r00 >= -16'sd16384) &&
			 (out_ch.r11 <= 16'sd16384) && (out_ch.r11 >= -16'sd16384) &&
			 (out_ch.r22 <= 16'sd16384) && (out_ch.r22 >= -16'sd16384)))
		else $error("matrix entry outside saturation range");

	// The output stage only fills from the sum stage.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s6) |-> $past(v_s5))
		else $error("result appeared without a sum stage beat");
`endif

endmodule
